@@ hw/rtl/bst_pkg.sv @@
// Package for the breakpoint slot table: action codes, register indexes,
// sequencer states and the structs passed between the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  // Default slot storage and the hard limit on comparators walked
  localparam int SLOTS_DEF       = 16;
  localparam int MAX_COMPARATORS = 16;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int ACT_W   = 3;
  localparam int CFG_IDX_W = 2;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_SET        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE_ALL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ACTIVATE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEACTIVATE = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd1;

  // Comparator enable bit set on every armed write
  localparam logic [ADDR_W-1:0] COMP_ARM = 32'h1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_STATUS
  } state_t;

  // One result word
  typedef struct packed {
    logic              is_write;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] comp_value;
    logic              ok;
    logic              last;
  } out_word_t;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic             enabled;
    logic [CNT_W-1:0] slot_count;
  } cfg_t;

  // Slot store write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] data;
  } store_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/bst_store.sv @@
// Slot address store: DEPTH entries of 32 bits, one read and one write port.
// Entries never written since reset read as zero (empty). Uses bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bst_store
  import bst_pkg::*;
#(
  parameter int DEPTH = SLOTS_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire store_wr_t         wr,
  output logic      [ADDR_W-1:0] rd_data
);

  logic [ADDR_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]  valid_r;

  // Mark written entries valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[idx] <= 1'b1;
    end
  end

  // Store entry data
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[idx] <= wr.data;
    end
  end

  // Read the walked entry, empty when never written
  assign rd_data = valid_r[idx] ? mem_r[idx] : '0;

endmodule

`default_nettype wire

@@ hw/rtl/bst_ctrl.sv @@
// Command sequencer: walks the slots one per cycle while no result word
// stalls, through a shared comparator, updates the store and emits
// comparator and status words. Uses bst_pkg; drives bst_store through the top level.
`timescale 1ns / 1ps
`default_nettype none

module bst_ctrl
  import bst_pkg::*;
#(
  parameter int DEPTH = SLOTS_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              clr_active,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic              out_free,
  output logic                   emit,
  output out_word_t              emit_word,
  output logic      [IDX_W-1:0]  st_idx,
  output store_wr_t              st_wr,
  input  wire logic [ADDR_W-1:0] st_rd_data
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  state_t            state_r, state_nxt;
  logic [ACT_W-1:0]  act_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  cnt_r, lim_r, lim_now;
  logic              ok_r, active_r;

  logic              in_fire;
  logic              start_ok;
  logic [ADDR_W-1:0] cmp_val;
  logic              eq, match, wants_emit, stall, finish;

  assign in_fire = in_valid && in_ready;
  assign lim_now = (cfg.slot_count < DEPTH_CNT) ? cfg.slot_count : DEPTH_CNT;

  // Commands that succeed whenever the unit is enabled
  always_comb begin
    case (in_action) inside
      ACT_REMOVE_ALL, ACT_ACTIVATE, ACT_DEACTIVATE: start_ok = cfg.enabled;
      default:                                      start_ok = 1'b0;
    endcase
  end

  // Shared comparator and walk decode
  always_comb begin
    cmp_val    = (act_r == ACT_REMOVE) ? addr_r : '0;
    eq         = (st_rd_data == cmp_val);
    match      = 1'b0;
    wants_emit = 1'b0;
    case (act_r)
      ACT_SET, ACT_REMOVE: begin
        match      = eq;
        wants_emit = eq && active_r;
      end
      ACT_REMOVE_ALL: begin
        match      = !eq;
        wants_emit = !eq && active_r;
      end
      default: begin
        match      = !eq;
        wants_emit = !eq;
      end
    endcase
    stall  = wants_emit && !out_free;
    finish = ((act_r == ACT_SET || act_r == ACT_REMOVE) && match)
             || ((cnt_r + CNT_W'(1)) == lim_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cfg.enabled && in_action <= ACT_DEACTIVATE && lim_now != '0) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_WALK: begin
        if (!stall && finish) begin
          state_nxt = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs per state
  always_comb begin
    in_ready  = 1'b0;
    emit      = 1'b0;
    emit_word = '0;
    st_idx    = cnt_r[IDX_W-1:0];
    st_wr     = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_WALK: begin
        if (!stall) begin
          emit                = wants_emit;
          emit_word.is_write  = 1'b1;
          emit_word.slot      = cnt_r[SLOT_W-1:0];
          case (act_r)
            ACT_SET:      emit_word.comp_value = addr_r | COMP_ARM;
            ACT_ACTIVATE: emit_word.comp_value = st_rd_data | COMP_ARM;
            default:      emit_word.comp_value = '0;
          endcase
          st_wr.en   = match && (act_r == ACT_SET || act_r == ACT_REMOVE
                                 || act_r == ACT_REMOVE_ALL);
          st_wr.data = (act_r == ACT_SET) ? addr_r : '0;
        end
      end
      ST_STATUS: begin
        emit         = out_free;
        emit_word.ok = ok_r;
        emit_word.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      lim_r    <= '0;
      ok_r     <= 1'b0;
      active_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        cnt_r <= '0;
        lim_r <= lim_now;
        ok_r  <= start_ok;
      end else if (state_r == ST_WALK && !stall) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (match && (act_r == ACT_SET || act_r == ACT_REMOVE)) begin
          ok_r <= 1'b1;
        end
      end
      // Disarm on an enable-register write, else arm or disarm once the command reports success
      if (clr_active) begin
        active_r <= 1'b0;
      end else if (state_r == ST_STATUS && out_free && ok_r) begin
        if (act_r == ACT_ACTIVATE) begin
          active_r <= 1'b1;
        end else if (act_r == ACT_DEACTIVATE) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  // Hold the command word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_action;
      addr_r <= in_address & ~COMP_ARM;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/breakpoint_slot_table.sv @@
// Top level of the breakpoint slot table: configuration registers, output
// word register, sequencer and slot store. Uses bst_pkg, bst_ctrl, bst_store.
`timescale 1ns / 1ps
`default_nettype none

// Breakpoint slot table. Each command word (set, remove, remove all,
// activate, deactivate) is taken while the block is idle and, when enabled
// with a nonzero slot count, walks the first min(slot_count, SLOTS, 16)
// slots, one slot per cycle unless the result side stalls a word, through a
// single comparator; set and remove stop at the first hit. Otherwise it goes
// straight to the status word. Comparator writes come out in slot order,
// followed by one status word with last set. Configuration writes are always
// ready; writing the enable register disarms the comparators. The store
// needs no clearing pass: entries not written since reset read as empty.
module breakpoint_slot_table
  import bst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ACT_W-1:0]     in_action,
  input  wire logic [ADDR_W-1:0]    in_address,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_is_write,
  output logic [SLOT_W-1:0]         out_slot,
  output logic [ADDR_W-1:0]         out_comp_value,
  output logic                      out_ok,
  output logic                      out_last
);

  localparam int DEPTH = (SLOTS < MAX_COMPARATORS) ? SLOTS : MAX_COMPARATORS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              enabled_r;
  logic [CNT_W-1:0]  slot_count_r;
  logic              cfg_fire, clr_active;
  cfg_t              cfg;

  logic              out_valid_r;
  out_word_t         out_word_r;
  logic              out_free, emit;
  out_word_t         emit_word;

  logic [IDX_W-1:0]  st_idx;
  store_wr_t         st_wr;
  logic [ADDR_W-1:0] st_rd_data;

  // Configuration registers
  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign clr_active = cfg_fire && (cfg_index == REG_ENABLED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      slot_count_r <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_ENABLED:    enabled_r    <= cfg_wdata[0];
        REG_SLOT_COUNT: slot_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.enabled    = enabled_r;
  assign cfg.slot_count = slot_count_r;

  // Output word register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= emit_word;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_write   = out_word_r.is_write;
  assign out_slot       = out_word_r.slot;
  assign out_comp_value = out_word_r.comp_value;
  assign out_ok         = out_word_r.ok;
  assign out_last       = out_word_r.last;

  bst_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .clr_active (clr_active),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_address (in_address),
    .out_free   (out_free),
    .emit       (emit),
    .emit_word  (emit_word),
    .st_idx     (st_idx),
    .st_wr      (st_wr),
    .st_rd_data (st_rd_data)
  );

  bst_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx     (st_idx),
    .wr      (st_wr),
    .rd_data (st_rd_data)
  );

  // After a command is accepted, the block is not ready in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // Status words and comparator writes are told apart by last
  a_last_vs_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_write != out_last))
    else $error("result word marks both or neither of write and last");

  // Comparator writes never carry a status
  a_write_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_write |-> !out_ok)
    else $error("comparator write carries ok");

  // Never load a new word over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !emit)
    else $error("result word overwritten while stalled");

endmodule

`default_nettype wire
